// ----- design/skf_pkg.sv -----
// Shared types and constants for the scalar Kalman filter.
`default_nettype none
package skf_pkg;

  localparam int EST_W = 16;
  localparam int VAR_W = 32;
  localparam int CFG_IDX_W = 4;

  typedef logic [EST_W-1:0]     est_t;
  typedef logic [VAR_W-1:0]     var_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_INIT_ESTIMATE     = 4'd0;
  localparam cfg_idx_t REG_INIT_VARIANCE     = 4'd1;
  localparam cfg_idx_t REG_MEASUREMENT_NOISE = 4'd2;
  localparam cfg_idx_t REG_PROCESS_NOISE     = 4'd3;

  localparam est_t RST_ESTIMATE = 16'd15000;
  localparam var_t RST_VARIANCE = 32'd1678;
  localparam var_t RST_MEAS_NOISE = 32'd16777;
  localparam var_t RST_PROC_NOISE = 32'd1678;

endpackage
`default_nettype wire

// ----- design/skf_ifs.sv -----
// Handshake channel interfaces: sample in, estimate out, register writes.
`default_nettype none
interface skf_in_if;
  import skf_pkg::*;
  logic valid;
  logic ready;
  est_t sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface skf_out_if;
  import skf_pkg::*;
  logic valid;
  logic ready;
  est_t estimate_out;
  modport source (output valid, output estimate_out, input ready);
  modport sink (input valid, input estimate_out, output ready);
endinterface

interface skf_cfg_if;
  import skf_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  var_t     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- design/skf_div.sv -----
// Radix-2 restoring divider producing the fractional gain one bit per cycle.
`default_nettype none
module skf_div #(
  parameter int FracBits = 24
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [31:0]       numer,
  input  wire logic [32:0]       denom,
  output logic                   done,
  output logic [FracBits:0]      quot
);
  import skf_pkg::*;

  localparam int CW = $clog2(FracBits);

  logic          running;
  logic [CW-1:0] cnt;
  logic [32:0]   rem;
  logic [33:0]   shifted;
  logic          ge;
  logic          int_bit;

  assign int_bit = {1'b0, numer} >= denom;
  assign shifted = {rem, 1'b0};
  assign ge      = shifted >= {1'b0, denom};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(FracBits - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= int_bit ? ({1'b0, numer} - denom) : {1'b0, numer};
      quot <= {{FracBits{1'b0}}, int_bit};
    end else if (running) begin
      rem  <= ge ? 33'(shifted - {1'b0, denom}) : shifted[32:0];
      quot <= {quot[FracBits-1:0], ge};
    end
  end

endmodule
`default_nettype wire

// ----- design/scalar_kalman_filter_top.sv -----
// Top level of the scalar Kalman filter over unsigned 16-bit samples.
//
// Channels: in_ch takes one sample per transfer, out_ch gives one updated
// estimate per sample, cfg writes registers by index (0 initial estimate,
// 1 initial variance, 2 measurement noise, 3 process noise). Writing index
// 0 or 1 also loads the estimate or variance state. cfg is always ready.
// The gain comes from a one-bit-per-cycle divider over the registered
// denominator, then estimate and variance are formed by bit-serial
// shift-add over gain and 1-gain and go to the result register. One
// sample is in work at a time: a new sample is taken only once the
// previous one has passed its result to the output register.
// Reset (synchronous, rst high) loads the estimate 15000, variance 1678,
// measurement noise 16777 and process noise 1678 and empties the block.
// A result waits in the output register while out_ch stalls; the next sample
// is already taken and worked on, and holds before writing its result until
// the output register is free.
`default_nettype none
module scalar_kalman_filter_top #(
  parameter int VAR_FRAC_BITS = 24
) (
  input wire logic  clk,
  input wire logic  rst,
  skf_in_if.sink    in_ch,
  skf_out_if.source out_ch,
  skf_cfg_if.sink   cfg
);
  import skf_pkg::*;

  localparam int F  = VAR_FRAC_BITS;
  localparam int CW = $clog2(F);
  localparam logic [F:0] ONE = (F+1)'(1) << F;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DEN  = 3'd1;
  localparam logic [2:0] ST_GO   = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]    state;
  est_t          estimate;
  var_t          variance;
  var_t          meas_noise;
  var_t          proc_noise;
  est_t          z;
  var_t          prior;
  logic [32:0]   denom;
  logic [F:0]    gain_sr;
  logic [F:0]    keep_sr;
  logic [16:0]   acc_e;
  logic [31:0]   acc_v;
  logic [CW-1:0] cnt;
  est_t          est_res;
  logic          out_valid;

  logic [32:0]   prior_sum;
  logic          div_done;
  logic [F:0]    quot;
  logic [F:0]    gain;
  logic [17:0]   ce;
  logic [17:0]   sum_e;
  logic [32:0]   sum_v;
  logic          in_xfer;
  logic          out_free;

  assign in_ch.ready         = (state == ST_IDLE);
  assign in_xfer             = in_ch.valid && in_ch.ready;
  assign cfg.ready           = 1'b1;
  assign out_ch.valid        = out_valid;
  assign out_ch.estimate_out = est_res;
  assign out_free            = !out_valid || out_ch.ready;

  assign prior_sum = {1'b0, variance} + {1'b0, proc_noise};
  assign gain      = (denom == 33'd0) ? '0 : quot;
  assign ce        = (keep_sr[0] ? {2'b0, estimate} : 18'd0) + (gain_sr[0] ? {2'b0, z} : 18'd0);
  assign sum_e     = {1'b0, acc_e} + ce;
  assign sum_v     = {1'b0, acc_v} + (keep_sr[0] ? {1'b0, prior} : 33'd0);

  skf_div #(.FracBits(F)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_GO),
    .numer (prior),
    .denom (denom),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      estimate   <= RST_ESTIMATE;
      variance   <= RST_VARIANCE;
      meas_noise <= RST_MEAS_NOISE;
      proc_noise <= RST_PROC_NOISE;
      cnt        <= '0;
    end else begin
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid) begin
        case (cfg.index)
          REG_INIT_ESTIMATE:     estimate   <= cfg.data[EST_W-1:0];
          REG_INIT_VARIANCE:     variance   <= cfg.data;
          REG_MEASUREMENT_NOISE: meas_noise <= cfg.data;
          REG_PROCESS_NOISE:     proc_noise <= cfg.data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            state <= ST_DEN;
          end
        end
        ST_DEN: state <= ST_GO;
        ST_GO:  state <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            cnt   <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(F - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          estimate <= sum_e[EST_W-1:0];
          variance <= sum_v[31:0];
          state    <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      z     <= in_ch.sample;
      prior <= prior_sum[32] ? 32'hFFFF_FFFF : prior_sum[31:0];
    end
    if (state == ST_DEN) begin
      denom <= {1'b0, prior} + {1'b0, meas_noise};
    end
    if (state == ST_DIV && div_done) begin
      gain_sr <= gain;
      keep_sr <= ONE - gain;
      acc_e   <= '0;
      acc_v   <= '0;
    end
    if (state == ST_MUL) begin
      acc_e   <= sum_e[17:1];
      acc_v   <= sum_v[32:1];
      gain_sr <= gain_sr >> 1;
      keep_sr <= keep_sr >> 1;
    end
    if (state == ST_OUT && out_free) begin
      est_res <= estimate;
    end
  end

endmodule
`default_nettype wire

// ----- dv/scalar_kalman_filter_top_test.sv -----
// Testbench for scalar_kalman_filter_top: directed and random samples against a bit-exact filter.
module scalar_kalman_filter_top_test;
  import skf_pkg::*;

  localparam int FRAC_BITS = 24;
  localparam logic [63:0] GAIN_ONE = 64'd1 << FRAC_BITS;
  localparam int SETTLE_CYCLES = 2 * FRAC_BITS + 5 + 20;
  localparam int LIMIT_CYCLES = 400000;
  localparam cfg_idx_t REG_UNUSED_LO = REG_PROCESS_NOISE + 1;
  localparam cfg_idx_t REG_UNUSED_HI = '1;

  logic clk = 1'b0;
  logic rst;

  skf_in_if  in_ch();
  skf_out_if out_ch();
  skf_cfg_if cfg_ch();

  scalar_kalman_filter_top #(.VAR_FRAC_BITS(FRAC_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg(cfg_ch)
  );

  always #10 clk = ~clk;

  // filter state and register copies
  est_t est_q;
  var_t var_q;
  est_t init_est;
  var_t init_var;
  var_t meas_noise;
  var_t proc_noise;

  est_t pending_estimates[$];
  int   fail_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic recv_hold;
  int   hold_span = 0;
  event hold_start;
  est_t drift_target = 16'd15000;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic est_t filter_step(input est_t z);
    logic [63:0] prior;
    logic [63:0] denom;
    logic [63:0] gain;
    logic [63:0] keep;
    logic [63:0] mixed;
    prior = 64'(var_q) + 64'(proc_noise);
    if (prior > 64'hFFFF_FFFF) prior = 64'hFFFF_FFFF;
    denom = prior + 64'(meas_noise);
    gain = (denom == 64'd0) ? 64'd0 : (prior << FRAC_BITS) / denom;
    if (gain > GAIN_ONE) gain = GAIN_ONE;
    keep = GAIN_ONE - gain;
    mixed = (64'(est_q) * keep + 64'(z) * gain) >> FRAC_BITS;
    est_q = est_t'(mixed);
    var_q = var_t'((prior * keep) >> FRAC_BITS);
    return est_q;
  endfunction

  function automatic void apply_reg_write(input cfg_idx_t idx, input var_t data);
    case (idx)
      REG_INIT_ESTIMATE: begin
        init_est = est_t'(data);
        est_q = init_est;
      end
      REG_INIT_VARIANCE: begin
        init_var = data;
        var_q = init_var;
      end
      REG_MEASUREMENT_NOISE: meas_noise = data;
      REG_PROCESS_NOISE: proc_noise = data;
      default: ;
    endcase
  endfunction

  // estimate checker
  always @(posedge clk) begin
    est_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_estimates.size() == 0) begin
        report_mismatch($sformatf("estimate %0d with nothing pending", out_ch.estimate_out));
      end else begin
        want = pending_estimates.pop_front();
        if (out_ch.estimate_out !== want)
          report_mismatch($sformatf("estimate_out got %0d want %0d",
                                    out_ch.estimate_out, want));
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // long receiver hold-off
  always begin
    @(hold_start);
    recv_hold <= 1'b1;
    repeat (hold_span) @(negedge clk);
    recv_hold <= 1'b0;
  end

  task automatic send_sample(input est_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    pending_estimates.push_back(filter_step(s));
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input var_t data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg_write(idx, data);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain_filter();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_estimates.size() != 0) @(negedge clk);
  endtask

  function automatic var_t pick_noise();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return var_t'($urandom_range(1 << 20));
      3: return var_t'($urandom_range(1 << 26));
      default: return var_t'($urandom());
    endcase
  endfunction

  function automatic est_t pick_sample();
    if ($urandom_range(1)) return est_t'($urandom());
    if ($urandom_range(15) == 0) drift_target = est_t'($urandom());
    return drift_target + est_t'($urandom_range(64)) - est_t'(32);
  endfunction

  task automatic configure_random();
    write_reg(REG_MEASUREMENT_NOISE, pick_noise());
    write_reg(REG_PROCESS_NOISE, pick_noise());
    write_reg(REG_INIT_VARIANCE, pick_noise());
    if ($urandom_range(1)) write_reg(REG_INIT_ESTIMATE, var_t'($urandom()));
    if ($urandom_range(3) == 0)
      write_reg(cfg_idx_t'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)), var_t'($urandom()));
  endtask

  task automatic test_reset_state();
    send_sample(16'd0);
    send_sample(16'hFFFF);
    send_sample(16'd15000);
  endtask

  task automatic test_zero_denominator();
    drain_filter();
    write_reg(REG_MEASUREMENT_NOISE, '0);
    write_reg(REG_PROCESS_NOISE, '0);
    write_reg(REG_INIT_VARIANCE, '0);
    send_sample(16'd0);
    send_sample(16'hFFFF);
    send_sample(16'd777);
  endtask

  task automatic test_prior_saturation();
    drain_filter();
    write_reg(REG_INIT_VARIANCE, '1);
    write_reg(REG_PROCESS_NOISE, '1);
    send_sample(16'hFFFF);
    send_sample(16'd0);
    drain_filter();
    write_reg(REG_MEASUREMENT_NOISE, '1);
    send_sample(16'hFFFF);
    send_sample(16'd0);
  endtask

  task automatic test_register_decode();
    drain_filter();
    write_reg(REG_UNUSED_LO, '1);
    write_reg(REG_UNUSED_HI, '1);
    write_reg(REG_INIT_ESTIMATE, 32'hA5A5_FFFF);
    write_reg(REG_MEASUREMENT_NOISE, var_t'(1) << FRAC_BITS);
    write_reg(REG_PROCESS_NOISE, '0);
    write_reg(REG_INIT_VARIANCE, var_t'(1) << FRAC_BITS);
    send_sample(16'd0);
    send_sample(16'hFFFF);
    drain_filter();
    write_reg(REG_INIT_ESTIMATE, 32'hFFFF_0000);
    send_sample(16'hFFFF);
    send_sample(16'd0);
  endtask

  task automatic test_sample_extremes();
    drain_filter();
    write_reg(REG_MEASUREMENT_NOISE, 32'd16777);
    write_reg(REG_PROCESS_NOISE, 32'd1678);
    write_reg(REG_INIT_VARIANCE, 32'h4000_0000);
    write_reg(REG_INIT_ESTIMATE, '0);
    send_sample(16'hFFFF);
    drain_filter();
    write_reg(REG_INIT_ESTIMATE, 32'hFFFF);
    send_sample(16'd0);
    repeat (3) begin
      send_sample(16'hFFFF);
      send_sample(16'd0);
    end
  endtask

  task automatic test_backpressure();
    drain_filter();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_span = 600;
    -> hold_start;
    repeat (12) send_sample(pick_sample());
    drain_filter();
  endtask

  task automatic test_random(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int part = 0; part < 2; part++) begin
      drain_filter();
      configure_random();
      repeat (n / 2) send_sample(pick_sample());
    end
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_INIT_ESTIMATE;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    recv_hold = 1'b0;
    init_est = RST_ESTIMATE;
    init_var = RST_VARIANCE;
    meas_noise = RST_MEAS_NOISE;
    proc_noise = RST_PROC_NOISE;
    est_q = init_est;
    var_q = init_var;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_state();
    test_zero_denominator();
    test_prior_saturation();
    test_register_decode();
    test_sample_extremes();
    test_backpressure();
    test_random(154, 0, 0);
    test_random(154, 80, 0);
    test_random(154, 0, 80);
    test_random(154, 17, 17);

    drain_filter();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_estimates.size() != 0)
      report_mismatch($sformatf("%0d estimates never arrived", pending_estimates.size()));
    if (fail_count == 0)
      $display("scalar_kalman_filter_top_test OK");
    else
      $display("scalar_kalman_filter_top_test NOT OK");
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 20);
    $display("timeout");
    $display("scalar_kalman_filter_top_test NOT OK");
    $finish;
  end

endmodule

// ----- files.f -----
design/skf_pkg.sv
design/skf_ifs.sv
design/skf_div.sv
design/scalar_kalman_filter_top.sv
dv/scalar_kalman_filter_top_test.sv
